FILE: hw/rtl/gfp_pkg.sv
// Shared types, constants and helpers for the GNSS frame receive parser.
package gfp_pkg;

  // Capture buffer depth seen by the consumer
  localparam int unsigned BUF_BYTES = 256;
  localparam int unsigned WPOS_W    = $clog2(BUF_BYTES);

  // Framing bytes
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] SYNC_CHAR1  = 8'hB5;
  localparam logic [7:0] SYNC_CHAR2  = 8'h62;

  // Output packing width (26 payload bits padded to 32)
  localparam int unsigned OUT_TDATA_W = 32;

  // Reported parser state codes
  localparam logic [3:0] PS_IDLE    = 4'd0;
  localparam logic [3:0] PS_TEXT    = 4'd1;
  localparam logic [3:0] PS_CR      = 4'd2;
  localparam logic [3:0] PS_SYNC1   = 4'd3;
  localparam logic [3:0] PS_HEADER  = 4'd4;
  localparam logic [3:0] PS_PAYLOAD = 4'd5;
  localparam logic [3:0] PS_CKA     = 4'd6;
  localparam logic [3:0] PS_CKB     = 4'd7;
  localparam logic [3:0] PS_END     = 4'd8;

  // Input command codes
  localparam logic CMD_DATA    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Header byte positions after increment
  localparam logic [2:0] HDR_LEN_LO = 3'd3;
  localparam logic [2:0] HDR_LEN_HI = 3'd4;

  // Receive state machine, one-hot
  typedef enum logic [8:0] {
    ST_IDLE    = 9'b0_0000_0001,
    ST_TEXT    = 9'b0_0000_0010,
    ST_CR      = 9'b0_0000_0100,
    ST_SYNC1   = 9'b0_0000_1000,
    ST_HEADER  = 9'b0_0001_0000,
    ST_PAYLOAD = 9'b0_0010_0000,
    ST_CKA     = 9'b0_0100_0000,
    ST_CKB     = 9'b0_1000_0000,
    ST_END     = 9'b1_0000_0000
  } rx_state_e;

  // Protocol of the current frame
  typedef enum logic [1:0] {
    PROTO_NONE = 2'd0,
    PROTO_BIN  = 2'd1,
    PROTO_TEXT = 2'd2
  } proto_e;

  // One accepted input item
  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [3:0] parser_state;
    logic [1:0] protocol;
    logic       frame_done;
    logic       checksum_bad;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       overflow;
  } result_t;

  // Map the one-hot state to its reported code
  function automatic logic [3:0] state_code(rx_state_e st);
    logic [3:0] code;
    unique case (st)
      ST_IDLE:    code = PS_IDLE;
      ST_TEXT:    code = PS_TEXT;
      ST_CR:      code = PS_CR;
      ST_SYNC1:   code = PS_SYNC1;
      ST_HEADER:  code = PS_HEADER;
      ST_PAYLOAD: code = PS_PAYLOAD;
      ST_CKA:     code = PS_CKA;
      ST_CKB:     code = PS_CKB;
      ST_END:     code = PS_END;
      default:    code = PS_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: hw/rtl/gfp_in_stage.sv
// Input register stage: holds one accepted item until the core takes it.
module gfp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gfp_pkg::in_item_t in_item_i,
  input  logic              take_i,
  output logic              item_valid_o,
  output gfp_pkg::in_item_t item_o
);
  import gfp_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  // Accept when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

FILE: hw/rtl/gfp_core.sv
// Parser state registers and the per-byte update logic.
module gfp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  gfp_pkg::in_item_t item_i,
  output gfp_pkg::result_t  result_o
);
  import gfp_pkg::*;

  rx_state_e          st_q, st_d;
  proto_e             proto_q, proto_d;
  logic [2:0]         hc_q, hc_d;
  logic [15:0]        len_q, len_d;
  logic [15:0]        pc_q, pc_d;
  logic [7:0]         sa_q, sa_d;
  logic [7:0]         sb_q, sb_d;
  logic [7:0]         rxa_q, rxa_d;
  logic               bad_q, bad_d;
  logic               full_q, full_d;
  logic [WPOS_W-1:0]  wpos_q, wpos_d;

  logic [7:0]         b;
  logic [2:0]         hc_inc;
  logic [15:0]        pc_inc;
  logic [15:0]        len_full;
  logic [7:0]         sa_add;
  logic               store;
  logic [WPOS_W+7:0]  wpos_ext;

  assign b        = item_i.data_byte;
  assign hc_inc   = hc_q + 3'd1;
  assign pc_inc   = pc_q + 16'd1;
  assign len_full = len_q | {b, 8'h00};
  assign sa_add   = sa_q + b;
  assign wpos_ext = {8'h00, wpos_q};

  // Next state for one byte or restart
  always_comb begin
    st_d    = st_q;
    proto_d = proto_q;
    hc_d    = hc_q;
    len_d   = len_q;
    pc_d    = pc_q;
    sa_d    = sa_q;
    sb_d    = sb_q;
    rxa_d   = rxa_q;
    bad_d   = bad_q;
    full_d  = full_q;
    wpos_d  = wpos_q;
    store   = 1'b0;

    if (item_i.cmd == CMD_RESTART) begin
      st_d    = ST_IDLE;
      proto_d = PROTO_NONE;
      hc_d    = '0;
      len_d   = '0;
      pc_d    = '0;
      sa_d    = '0;
      sb_d    = '0;
      rxa_d   = '0;
      bad_d   = 1'b0;
      full_d  = 1'b0;
      wpos_d  = '0;
    end else if (st_q != ST_END) begin
      unique case (st_q)
        ST_IDLE: begin
          if (b == SYNC_CHAR1) begin
            proto_d = PROTO_BIN;
            st_d    = ST_SYNC1;
          end else if (b == CHAR_DOLLAR) begin
            proto_d = PROTO_TEXT;
            st_d    = ST_TEXT;
          end
        end
        ST_TEXT: begin
          if (b == CHAR_CR) begin
            st_d = ST_CR;
          end
        end
        ST_CR: begin
          if (b == CHAR_LF) begin
            st_d = ST_END;
          end else begin
            proto_d = PROTO_NONE;
            st_d    = ST_IDLE;
          end
        end
        ST_SYNC1: begin
          if (b == SYNC_CHAR2) begin
            st_d = ST_HEADER;
            hc_d = '0;
          end else begin
            proto_d = PROTO_NONE;
            st_d    = ST_IDLE;
          end
        end
        ST_HEADER: begin
          sa_d = sa_add;
          sb_d = sb_q + sa_add;
          hc_d = hc_inc;
          if (hc_inc == HDR_LEN_LO) begin
            len_d = {8'h00, b};
          end else if (hc_inc >= HDR_LEN_HI) begin
            len_d = len_full;
            pc_d  = '0;
            st_d  = (len_full == 16'd0) ? ST_CKA : ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: begin
          sa_d = sa_add;
          sb_d = sb_q + sa_add;
          if (pc_inc >= len_q) begin
            st_d = ST_CKA;
            pc_d = '0;
          end else begin
            pc_d = pc_inc;
          end
        end
        ST_CKA: begin
          rxa_d = b;
          st_d  = ST_CKB;
        end
        ST_CKB: begin
          st_d = ST_END;
          if (rxa_q != sa_q || b != sb_q) begin
            bad_d = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // With room in the buffer, store the byte unless the next state is idle; else flag overflow
      if (wpos_q < WPOS_W'(BUF_BYTES - 1)) begin
        if (st_d != ST_IDLE) begin
          store  = 1'b1;
          wpos_d = wpos_q + WPOS_W'(1);
        end
      end else begin
        full_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      proto_q <= PROTO_NONE;
      hc_q    <= '0;
      len_q   <= '0;
      pc_q    <= '0;
      sa_q    <= '0;
      sb_q    <= '0;
      rxa_q   <= '0;
      bad_q   <= 1'b0;
      full_q  <= 1'b0;
      wpos_q  <= '0;
    end else if (step_i) begin
      st_q    <= st_d;
      proto_q <= proto_d;
      hc_q    <= hc_d;
      len_q   <= len_d;
      pc_q    <= pc_d;
      sa_q    <= sa_d;
      sb_q    <= sb_d;
      rxa_q   <= rxa_d;
      bad_q   <= bad_d;
      full_q  <= full_d;
      wpos_q  <= wpos_d;
    end
  end

  // Result for this item
  always_comb begin
    result_o.parser_state = state_code(st_d);
    result_o.protocol     = proto_d;
    result_o.frame_done   = (st_d == ST_END);
    result_o.checksum_bad = bad_d;
    result_o.store_valid  = store;
    result_o.store_index  = store ? wpos_ext[7:0] : 8'h00;
    result_o.store_byte   = store ? b : 8'h00;
    result_o.overflow     = full_d;
  end

endmodule

FILE: hw/rtl/gfp_out_stage.sv
// Result register: holds one result item until the receiver takes it.
module gfp_out_stage (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 load_i,
  input  gfp_pkg::result_t                     result_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [gfp_pkg::OUT_TDATA_W-1:0]      out_data_o
);
  import gfp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  // Pack fields, first field in the lowest bits
  assign out_data_o = {6'b0,
                       res_q.overflow,
                       res_q.store_byte,
                       res_q.store_index,
                       res_q.store_valid,
                       res_q.checksum_bad,
                       res_q.frame_done,
                       res_q.protocol,
                       res_q.parser_state};
  assign out_valid_o = valid_q;

endmodule

FILE: hw/rtl/gnss_frame_receive_parser_top.sv
// Top level of the GNSS frame receive parser.
//
// Input stream: one item per received byte. tdata carries the byte,
// tuser the command (data byte, or restart that clears parser and flags).
// Output stream: one result item per input item, in order, carrying the
// parser state, protocol, done and sticky error flags, and the capture
// buffer write (valid, index, byte) the consumer applies to its buffer.
// Path: an accepted item sits in the input register, and its result loads
// into the result register once that register is empty or being taken,
// after which the receiver can take it.
// Throughput: one item per cycle while tready is high; each byte's state
// update is a single compare/add step between the input and result registers.
// Reset: all parser state clears to idle, protocol unknown, flags low;
// both stages come up empty.
// Stall: when the receiver holds tready low the result register keeps its
// item; one more item waits in the input register, after which tready on
// the input side drops until the output moves again.
module gnss_frame_receive_parser_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,  // [7:0] data_byte
  input  logic                                 s_axis_tuser,  // [0] cmd
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [3:0] parser_state, [5:4] protocol, [6] frame_done, [7] checksum_bad,
  // [8] store_valid, [16:9] store_index, [24:17] store_byte, [25] overflow
  output logic [gfp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import gfp_pkg::*;

  in_item_t in_item;
  in_item_t held_item;
  logic     held_valid;
  logic     step;
  result_t  result;

  assign in_item.cmd       = s_axis_tuser;
  assign in_item.data_byte = s_axis_tdata;

  // Advance the held item when the result register can take its result
  assign step = held_valid && (!m_axis_tvalid || m_axis_tready);

  gfp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .take_i       (step),
    .item_valid_o (held_valid),
    .item_o       (held_item)
  );

  gfp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (held_item),
    .result_o (result)
  );

  gfp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (result),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

FILE: hw/rtl/gfp_checker.sv
// Port-level assertions for the GNSS frame receive parser, bound to the top.
module gfp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [gfp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import gfp_pkg::*;

  logic [3:0] o_state;
  logic [1:0] o_proto;
  logic       o_done;
  logic       o_bad;
  logic       o_store;
  logic [7:0] o_index;
  logic [7:0] o_byte;

  assign o_state = m_axis_tdata[3:0];
  assign o_proto = m_axis_tdata[5:4];
  assign o_done  = m_axis_tdata[6];
  assign o_bad   = m_axis_tdata[7];
  assign o_store = m_axis_tdata[8];
  assign o_index = m_axis_tdata[16:9];
  assign o_byte  = m_axis_tdata[24:17];

  // Done flag tracks the end state
  a_done_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (o_done == (o_state == PS_END)))
    else $error("frame_done disagrees with parser_state");

  // No buffer write in idle, and unstored items carry zero index and byte
  a_store_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (o_store ? (o_state != PS_IDLE)
                               : (o_index == 8'h00 && o_byte == 8'h00)))
    else $error("store fields inconsistent");

  // A checksum error only exists in a binary frame
  a_bad_is_binary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && o_bad) |-> (o_proto == PROTO_BIN))
    else $error("checksum_bad outside a binary frame");

  // Stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

endmodule

bind gnss_frame_receive_parser_top gfp_checker u_gfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/sv/gnss_frame_receive_parser_top_tb.sv
// Testbench for gnss_frame_receive_parser_top: directed table plus framed random traffic.
module gnss_frame_receive_parser_top_tb;
  import gfp_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RAND_ITEMS  = 1000;
  localparam int unsigned DIR_N       = 25;

  // Directed row: item plus an optional hand-written result
  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       fixed;
    result_t    res;
  } dir_row_t;

  localparam result_t R_CLEAR  = '0;
  localparam result_t R_DOLLAR = '{PS_TEXT, PROTO_TEXT, 1'b0, 1'b0, 1'b1, 8'd0,
                                   CHAR_DOLLAR, 1'b0};

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{CMD_RESTART, 8'h00, 1'b1, R_CLEAR},   // restart straight after reset
    '{CMD_DATA, 8'h00, 1'b1, R_CLEAR},      // junk in idle is not stored
    '{CMD_DATA, 8'hFF, 1'b1, R_CLEAR},
    '{CMD_DATA, CHAR_DOLLAR, 1'b1, R_DOLLAR},
    '{CMD_DATA, 8'h41, 1'b0, R_CLEAR},
    '{CMD_DATA, CHAR_CR, 1'b0, R_CLEAR},
    '{CMD_DATA, 8'h78, 1'b1, R_CLEAR},      // missing LF drops back to idle
    '{CMD_DATA, SYNC_CHAR1, 1'b0, R_CLEAR},
    '{CMD_DATA, 8'h00, 1'b1, R_CLEAR},      // broken second sync byte
    '{CMD_DATA, SYNC_CHAR1, 1'b0, R_CLEAR},
    '{CMD_DATA, SYNC_CHAR2, 1'b0, R_CLEAR},
    '{CMD_DATA, 8'h01, 1'b0, R_CLEAR},
    '{CMD_DATA, 8'h07, 1'b0, R_CLEAR},
    '{CMD_DATA, 8'h00, 1'b0, R_CLEAR},      // zero-length payload
    '{CMD_DATA, 8'h00, 1'b0, R_CLEAR},
    '{CMD_DATA, 8'h08, 1'b0, R_CLEAR},      // good checksum
    '{CMD_DATA, 8'h19, 1'b0, R_CLEAR},
    '{CMD_DATA, SYNC_CHAR1, 1'b0, R_CLEAR}, // ignored after end
    '{CMD_RESTART, 8'hFF, 1'b1, R_CLEAR},
    '{CMD_DATA, CHAR_DOLLAR, 1'b1, R_DOLLAR},
    '{CMD_DATA, CHAR_CR, 1'b0, R_CLEAR},
    '{CMD_DATA, CHAR_LF, 1'b0, R_CLEAR},
    '{CMD_DATA, 8'hFF, 1'b0, R_CLEAR},
    '{CMD_RESTART, 8'h55, 1'b1, R_CLEAR},
    '{CMD_DATA, 8'h80, 1'b1, R_CLEAR}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = 8'h00;
  logic                   s_axis_tuser = CMD_DATA;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Parser shadow state
  logic [3:0]  p_state = PS_IDLE;
  proto_e      p_proto = PROTO_NONE;
  logic [2:0]  hdr_cnt = '0;
  logic [15:0] pay_len = '0;
  logic [15:0] pay_cnt = '0;
  logic [7:0]  ck_a_acc = '0;
  logic [7:0]  ck_b_acc = '0;
  logic [7:0]  ck_a_rx = '0;
  logic        sum_err = 1'b0;
  logic        buf_full = 1'b0;
  int unsigned wr_pos = 0;

  result_t parse_results_q [$];
  result_t want_res;
  int      err_cnt = 0;
  int      n_sent = 0;
  int      stall_cyc = 0;
  int      hold_reqs = 0;
  int      hold_seen = 0;
  int      hold_left = 0;
  bit      src_idle_en = 1'b1;
  bit      snk_idle_en = 1'b1;

  gnss_frame_receive_parser_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Advance the shadow parser by one item and return its result
  function automatic result_t parse_byte(logic cmd, logic [7:0] b);
    result_t r;
    r = '0;
    if (cmd == CMD_RESTART) begin
      p_state  = PS_IDLE;
      p_proto  = PROTO_NONE;
      hdr_cnt  = '0;
      pay_len  = '0;
      pay_cnt  = '0;
      ck_a_acc = '0;
      ck_b_acc = '0;
      ck_a_rx  = '0;
      sum_err  = 1'b0;
      buf_full = 1'b0;
      wr_pos   = 0;
    end else if (p_state != PS_END) begin
      case (p_state)
        PS_IDLE: begin
          if (b == SYNC_CHAR1) begin
            p_proto = PROTO_BIN;
            p_state = PS_SYNC1;
          end else if (b == CHAR_DOLLAR) begin
            p_proto = PROTO_TEXT;
            p_state = PS_TEXT;
          end
        end
        PS_TEXT: begin
          if (b == CHAR_CR) p_state = PS_CR;
        end
        PS_CR: begin
          if (b == CHAR_LF) begin
            p_state = PS_END;
          end else begin
            p_proto = PROTO_NONE;
            p_state = PS_IDLE;
          end
        end
        PS_SYNC1: begin
          if (b == SYNC_CHAR2) begin
            p_state = PS_HEADER;
            hdr_cnt = '0;
          end else begin
            p_proto = PROTO_NONE;
            p_state = PS_IDLE;
          end
        end
        PS_HEADER: begin
          ck_a_acc = ck_a_acc + b;
          ck_b_acc = ck_b_acc + ck_a_acc;
          hdr_cnt  = hdr_cnt + 3'd1;
          if (hdr_cnt == HDR_LEN_LO) begin
            pay_len = {8'h00, b};
          end else if (hdr_cnt >= HDR_LEN_HI) begin
            pay_len = pay_len | {b, 8'h00};
            pay_cnt = '0;
            p_state = (pay_len == 16'd0) ? PS_CKA : PS_PAYLOAD;
          end
        end
        PS_PAYLOAD: begin
          ck_a_acc = ck_a_acc + b;
          ck_b_acc = ck_b_acc + ck_a_acc;
          pay_cnt  = pay_cnt + 16'd1;
          if (pay_cnt >= pay_len) begin
            p_state = PS_CKA;
            pay_cnt = '0;
          end
        end
        PS_CKA: begin
          ck_a_rx = b;
          p_state = PS_CKB;
        end
        PS_CKB: begin
          p_state = PS_END;
          if (ck_a_rx != ck_a_acc || b != ck_b_acc) sum_err = 1'b1;
        end
        default: ;
      endcase
      // Store into the capture buffer unless full or back in idle
      if (wr_pos < BUF_BYTES - 1) begin
        if (p_state != PS_IDLE) begin
          r.store_valid = 1'b1;
          r.store_index = 8'(wr_pos);
          r.store_byte  = b;
          wr_pos++;
        end
      end else begin
        buf_full = 1'b1;
      end
    end
    r.parser_state = p_state;
    r.protocol     = p_proto;
    r.frame_done   = (p_state == PS_END);
    r.checksum_bad = sum_err;
    r.overflow     = buf_full;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // Offer one item, wait for acceptance, queue its expected result
  task automatic send_item(logic cmd, logic [7:0] b, logic fixed = 1'b0,
                           result_t fixed_res = '0);
    logic    skip;
    result_t pred;
    while (src_idle_en && $urandom_range(0, 99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    skip = (cmd == CMD_DATA && p_state == PS_END);
    pred = parse_byte(cmd, b);
    parse_results_q.push_back(fixed ? fixed_res : pred);
    if (!skip) n_sent++;
  endtask

  // Binary frame with optional corrupted checksum
  task automatic send_binary(logic [15:0] len, bit bad_ck);
    logic [7:0]  sa, sb, v;
    logic [7:0]  hdr [4];
    int unsigned i;
    sa = '0;
    sb = '0;
    hdr[0] = 8'($urandom_range(0, 255));
    hdr[1] = 8'($urandom_range(0, 255));
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    send_item(CMD_DATA, SYNC_CHAR1);
    send_item(CMD_DATA, SYNC_CHAR2);
    for (i = 0; i < 4 + len; i++) begin
      v  = (i < 4) ? hdr[i[1:0]] : 8'($urandom_range(0, 255));
      sa = sa + v;
      sb = sb + sa;
      send_item(CMD_DATA, v);
    end
    if (bad_ck) begin
      if ($urandom_range(0, 1)) sa = sa ^ (8'd1 << $urandom_range(0, 7));
      else sb = sb ^ (8'd1 << $urandom_range(0, 7));
    end
    send_item(CMD_DATA, sa);
    send_item(CMD_DATA, sb);
  endtask

  // Text line, optionally with the LF replaced
  task automatic send_text(bit drop_lf);
    logic [7:0] v;
    int         n, i;
    n = $urandom_range(0, 20);
    send_item(CMD_DATA, CHAR_DOLLAR);
    for (i = 0; i < n; i++) begin
      v = 8'($urandom_range(0, 255));
      if (v == CHAR_CR) v = v ^ 8'h80;
      send_item(CMD_DATA, v);
    end
    send_item(CMD_DATA, CHAR_CR);
    if (drop_lf) begin
      v = 8'($urandom_range(0, 255));
      if (v == CHAR_LF) v = v ^ 8'h40;
      send_item(CMD_DATA, v);
    end else begin
      send_item(CMD_DATA, CHAR_LF);
    end
  endtask

  // Drive receiver ready: random idling, or a long hold when requested
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen     <= hold_reqs;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (snk_idle_en) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 35);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (parse_results_q.size() == 0) begin
        $error("result with nothing pending: %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want_res = parse_results_q.pop_front();
        check_field("parser_state", want_res.parser_state, m_axis_tdata[3:0]);
        check_field("protocol", want_res.protocol, m_axis_tdata[5:4]);
        check_field("frame_done", want_res.frame_done, m_axis_tdata[6]);
        check_field("checksum_bad", want_res.checksum_bad, m_axis_tdata[7]);
        check_field("store_valid", want_res.store_valid, m_axis_tdata[8]);
        check_field("store_index", want_res.store_index, m_axis_tdata[16:9]);
        check_field("store_byte", want_res.store_byte, m_axis_tdata[24:17]);
        check_field("overflow", want_res.overflow, m_axis_tdata[25]);
      end
    end
  end

  // Count cycles in which work is pending but nothing moves
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (!s_axis_tvalid && parse_results_q.size() == 0)) begin
      stall_cyc <= 0;
    end else begin
      stall_cyc <= stall_cyc + 1;
    end
  end

  initial begin
    wait (stall_cyc >= STALL_LIMIT);
    $display("FAIL gnss_frame_receive_parser_top");
    $finish;
  end

  initial begin
    int         i, pick, n;
    bit         hold_done, drain_done;
    logic [15:0] len;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (i = 0; i < DIR_N; i++) begin
      send_item(DIR_ROWS[i].cmd, DIR_ROWS[i].data, DIR_ROWS[i].fixed, DIR_ROWS[i].res);
    end

    // Random framed traffic
    n_sent = 0;
    while (n_sent < RAND_ITEMS) begin
      src_idle_en = !(n_sent >= 400 && n_sent < 550);
      snk_idle_en = src_idle_en;
      if (!hold_done && n_sent >= 300) begin
        hold_reqs++;
        hold_done = 1'b1;
      end
      if (!drain_done && n_sent >= 650) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (parse_results_q.size() != 0);
        drain_done = 1'b1;
      end
      if ($urandom_range(0, 99) < 70) send_item(CMD_RESTART, 8'($urandom_range(0, 255)));
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        n = $urandom_range(0, 99);
        if (n < 85) len = 16'($urandom_range(0, 12));
        else if (n < 95) len = 16'($urandom_range(13, 60));
        else len = 16'($urandom_range(200, 300));
        send_binary(len, pick >= 45);
      end else if (pick < 60) begin
        send_item(CMD_DATA, SYNC_CHAR1);
        send_item(CMD_DATA, 8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        send_text(pick >= 85);
      end else begin
        n = $urandom_range(3, 10);
        for (i = 0; i < n; i++) send_item(CMD_DATA, 8'($urandom_range(0, 255)));
      end
      // Trailing bytes, mostly ignored after the frame end
      n = $urandom_range(0, 2);
      for (i = 0; i < n; i++) send_item(CMD_DATA, 8'($urandom_range(0, 255)));
    end

    // Let the pipeline empty
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (parse_results_q.size() != 0);
    repeat (8) @(posedge clk_i);
    if (parse_results_q.size() != 0) begin
      $error("%0d results never arrived", parse_results_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("PASS gnss_frame_receive_parser_top");
    end else begin
      $display("FAIL gnss_frame_receive_parser_top");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/gfp_pkg.sv
hw/rtl/gfp_in_stage.sv
hw/rtl/gfp_core.sv
hw/rtl/gfp_out_stage.sv
hw/rtl/gnss_frame_receive_parser_top.sv
hw/rtl/gfp_checker.sv
tb/sv/gnss_frame_receive_parser_top_tb.sv
